// ----- rtl/core/cpu6502_execute_subset_macros.svh -----
// assertion helpers shared by the execute core
`ifndef CPU6502_EXECUTE_SUBSET_MACROS_SVH
`define CPU6502_EXECUTE_SUBSET_MACROS_SVH

// checked only out of reset
`define C6502_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every edge, reset included
`define C6502_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- rtl/core/c6502ex_pkg.sv -----
package c6502ex_pkg;

  localparam int unsigned CmdW = 5;

  typedef enum logic [CmdW-1:0] {
    CMD_ADC = 5'd0,
    CMD_AND = 5'd1,
    CMD_ASL = 5'd2,
    CMD_CLC = 5'd3,
    CMD_CMP = 5'd4,
    CMD_DEC = 5'd5,
    CMD_DEX = 5'd6,
    CMD_DEY = 5'd7,
    CMD_EOR = 5'd8,
    CMD_JMP = 5'd9,
    CMD_LDA = 5'd10,
    CMD_LDX = 5'd11,
    CMD_LDY = 5'd12,
    CMD_NOP = 5'd13,
    CMD_SEC = 5'd14,
    CMD_STA = 5'd15,
    CMD_STX = 5'd16,
    CMD_STY = 5'd17
  } cmd_e;

  typedef struct packed {
    logic [7:0]  acc;
    logic [7:0]  idx_x;
    logic [7:0]  idx_y;
    logic [15:0] pc;
    logic        carry;
    logic        zero;
    logic        neg;
  } arch_t;

  localparam arch_t ArchReset = '0;

endpackage

// ----- rtl/core/cpu6502_execute_subset.sv -----
// Executes one instruction of a 6502 subset per request: ADC, AND, ASL, CLC, CMP, DEC,
// DEX, DEY, EOR, JMP, LDA, LDX, LDY, NOP, SEC, STA, STX, STY (unused codes act as NOP).
// A request is captured in an input register; an 8-bit ALU reads it together with A,
// X, Y, PC and the C/Z/N flags and, when the request advances, writes the new state and
// the result register at once. The combinational ALU closing the loop through the state
// registers sets the rate: one request per cycle, stalling only when the result register
// is full and not taken. The write-back byte is zero whenever its enable is low. Overflow
// and decimal mode are not implemented.
`include "cpu6502_execute_subset_macros.svh"

module cpu6502_execute_subset
  import c6502ex_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [4:0]  command_i,
  input  logic [7:0]  operand_value_i,
  input  logic [15:0] jump_target_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        mem_write_enable_o,
  output logic [7:0]  mem_write_data_o,
  output logic [7:0]  acc_out_o,
  output logic [7:0]  index_x_out_o,
  output logic [7:0]  index_y_out_o,
  output logic [15:0] prog_counter_out_o,
  output logic        carry_out_o,
  output logic        zero_out_o,
  output logic        negative_out_o
);

  logic        req_valid_q;
  logic [4:0]  req_cmd_q;
  logic [7:0]  req_opnd_q;
  logic [15:0] req_target_q;

  arch_t       arch_q, arch_d;
  logic        wen_d;
  logic [7:0]  wdata_d;
  logic [8:0]  sum;
  logic [8:0]  diff;
  logic [7:0]  zn_val;
  logic        zn_upd;

  logic        out_valid_q;
  logic        out_wen_q;
  logic [7:0]  out_wdata_q;
  arch_t       out_arch_q;

  logic        advance;

  assign advance    = req_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !req_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      req_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      req_cmd_q    <= command_i;
      req_opnd_q   <= operand_value_i;
      req_target_q <= jump_target_i;
    end
  end

  assign sum  = {1'b0, arch_q.acc} + {1'b0, req_opnd_q} + {8'b0, arch_q.carry};
  assign diff = {1'b0, arch_q.acc} - {1'b0, req_opnd_q};

  always_comb begin
    arch_d  = arch_q;
    wen_d   = 1'b0;
    wdata_d = '0;
    zn_val  = '0;
    zn_upd  = 1'b0;
    case (req_cmd_q)
      CMD_ADC: begin
        arch_d.acc   = sum[7:0];
        arch_d.carry = sum[8];
        zn_val       = sum[7:0];
        zn_upd       = 1'b1;
      end
      CMD_AND: begin
        arch_d.acc = arch_q.acc & req_opnd_q;
        zn_val     = arch_d.acc;
        zn_upd     = 1'b1;
      end
      CMD_ASL: begin
        wen_d        = 1'b1;
        wdata_d      = {req_opnd_q[6:0], 1'b0};
        arch_d.carry = req_opnd_q[7];
        zn_val       = wdata_d;
        zn_upd       = 1'b1;
      end
      CMD_CLC: arch_d.carry = 1'b0;
      CMD_CMP: begin
        arch_d.carry = !diff[8];
        arch_d.zero  = (arch_q.acc == req_opnd_q);
        arch_d.neg   = diff[7];
      end
      CMD_DEC: begin
        wen_d   = 1'b1;
        wdata_d = req_opnd_q - 8'd1;
        zn_val  = wdata_d;
        zn_upd  = 1'b1;
      end
      CMD_DEX: begin
        arch_d.idx_x = arch_q.idx_x - 8'd1;
        zn_val       = arch_d.idx_x;
        zn_upd       = 1'b1;
      end
      CMD_DEY: begin
        arch_d.idx_y = arch_q.idx_y - 8'd1;
        zn_val       = arch_d.idx_y;
        zn_upd       = 1'b1;
      end
      CMD_EOR: begin
        arch_d.acc = arch_q.acc ^ req_opnd_q;
        zn_val     = arch_d.acc;
        zn_upd     = 1'b1;
      end
      CMD_JMP: arch_d.pc = req_target_q;
      CMD_LDA: begin
        arch_d.acc = req_opnd_q;
        zn_val     = req_opnd_q;
        zn_upd     = 1'b1;
      end
      CMD_LDX: begin
        arch_d.idx_x = req_opnd_q;
        zn_val       = req_opnd_q;
        zn_upd       = 1'b1;
      end
      CMD_LDY: begin
        arch_d.idx_y = req_opnd_q;
        zn_val       = req_opnd_q;
        zn_upd       = 1'b1;
      end
      CMD_NOP: ;
      CMD_SEC: arch_d.carry = 1'b1;
      CMD_STA: begin
        wen_d   = 1'b1;
        wdata_d = arch_q.acc;
      end
      CMD_STX: begin
        wen_d   = 1'b1;
        wdata_d = arch_q.idx_x;
      end
      CMD_STY: begin
        wen_d   = 1'b1;
        wdata_d = arch_q.idx_y;
      end
      default: ;
    endcase
    if (zn_upd) begin
      arch_d.zero = (zn_val == 8'd0);
      arch_d.neg  = zn_val[7];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arch_q      <= ArchReset;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        arch_q <= arch_d;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_wen_q   <= wen_d;
      out_wdata_q <= wdata_d;
      out_arch_q  <= arch_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign mem_write_enable_o = out_wen_q;
  assign mem_write_data_o   = out_wdata_q;
  assign acc_out_o          = out_arch_q.acc;
  assign index_x_out_o      = out_arch_q.idx_x;
  assign index_y_out_o      = out_arch_q.idx_y;
  assign prog_counter_out_o = out_arch_q.pc;
  assign carry_out_o        = out_arch_q.carry;
  assign zero_out_o         = out_arch_q.zero;
  assign negative_out_o     = out_arch_q.neg;

  `C6502_ASSERT(a_wdata_zero_when_idle,
    out_valid_q && !out_wen_q |-> out_wdata_q == 8'd0, "write data not zero without enable")
  `C6502_ASSERT(a_result_matches_state,
    out_valid_q |-> out_arch_q == arch_q, "pending result differs from state")
  `C6502_ASSERT(a_jmp_loads_pc,
    advance && req_cmd_q == CMD_JMP |=> arch_q.pc == $past(req_target_q), "jmp did not load pc")
  `C6502_ASSERT(a_pc_only_on_jmp,
    !(advance && req_cmd_q == CMD_JMP) |=> $stable(arch_q.pc), "pc changed without jmp")
  `C6502_ASSERT_ALWAYS(a_stall_only_when_full,
    !in_ready_o |-> req_valid_q && out_valid_q && !out_ready_i, "input stalled with room")

endmodule
